### src/hkvs_pkg.sv
// ----------------------------------------------------------------------------
// hkvs_pkg
// shared types and constants of the hashed key-value store
// ----------------------------------------------------------------------------
package hkvs_pkg;

    localparam int DEF_BUCKETS = 64;
    localparam int DEF_SLOTS   = 4;
    localparam int KEY_W       = 32;
    localparam int COUNT_W     = 9;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_MISSING = 2'd1,
        STAT_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_SCAN,
        S_UPDATE
    } t_state;

    typedef struct packed {
        t_op                     operation;
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] value;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic                    key_was_present;
        logic signed [KEY_W-1:0] found_value;
        logic [COUNT_W-1:0]      entry_count;
    } t_rsp;

endpackage

### src/hkvs_ram.sv
// ----------------------------------------------------------------------------
// hkvs_ram
// generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module hkvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/hkvs_hash.sv
// ----------------------------------------------------------------------------
// hkvs_hash
// bucket index of a signed key: non-negative remainder modulo the bucket count
// ----------------------------------------------------------------------------
module hkvs_hash #(
    parameter int BUCKETS = hkvs_pkg::DEF_BUCKETS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_start,
    input  logic [hkvs_pkg::KEY_W-1:0]                  i_key,
    output logic                                        o_done,
    output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] o_bucket
);

    import hkvs_pkg::*;

    localparam int     BKW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int     LB       = $clog2(BUCKETS);
    localparam int     RW       = LB + 1;
    localparam bit     IS_POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam int     SHIFT    = KEY_W - 1 + LB;
    localparam longint RECIP    = (64'sd1 <<< SHIFT) / BUCKETS;
    localparam longint WRAP_MOD = 64'sd4294967296 % BUCKETS;
    localparam logic [RW-1:0]    NEG_ADJ  = RW'(WRAP_MOD);
    localparam logic [RW-1:0]    B_R      = RW'(BUCKETS);
    localparam logic [KEY_W-1:0] MASK     = KEY_W'(BUCKETS - 1);
    localparam logic [KEY_W-1:0] RECIP_W  = KEY_W'(RECIP);

    logic [KEY_W-1:0]   r_key;
    logic [RW-1:0]      r_qlo;
    logic [RW-1:0]      r_rem;
    logic               r_mul;
    logic               r_red;
    logic               r_fix;
    logic               r_neg;
    logic               r_done;

    logic [2*KEY_W-1:0] mul_full;
    logic [RW-1:0]      mul_q;
    logic [RW-1:0]      red_prod;
    logic [RW-1:0]      red_raw;
    logic [RW-1:0]      red_rem;
    logic [RW-1:0]      fix_rem;

    // quotient estimate by reciprocal multiply, low for at most one bucket
    always_comb begin
        mul_full = {{KEY_W{1'b0}}, r_key} * {{KEY_W{1'b0}}, RECIP_W};
        mul_q    = RW'(mul_full >> SHIFT);
        red_prod = r_qlo * B_R;
        red_raw  = r_key[RW-1:0] - red_prod;
        red_rem  = (red_raw >= B_R) ? (red_raw - B_R) : red_raw;
        if (!r_neg) begin
            fix_rem = r_rem;
        end else if (r_rem >= NEG_ADJ) begin
            fix_rem = r_rem - NEG_ADJ;
        end else begin
            fix_rem = r_rem + B_R - NEG_ADJ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_red  <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_mul  <= i_start && !IS_POW2;
            r_red  <= r_mul;
            r_fix  <= r_red;
            r_done <= (i_start && IS_POW2) || r_fix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
            r_neg <= i_key[KEY_W-1];
            r_rem <= IS_POW2 ? RW'(i_key & MASK) : '0;
        end else if (r_mul) begin
            r_qlo <= mul_q;
        end else if (r_red) begin
            r_rem <= red_rem;
        end else if (r_fix) begin
            r_rem <= fix_rem;
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem[BKW-1:0];

endmodule

### src/hashed_key_value_store.sv
// ----------------------------------------------------------------------------
// hashed_key_value_store
// signed 32-bit key to value map in fixed buckets with a few slots each
// ----------------------------------------------------------------------------
// A request (insert or update, remove, find, clear) is taken at a clock edge
// where start is high and busy is low. Exactly one result comes back on
// o_rsp, marked by o_valid for a single cycle; the receiver cannot hold it.
// The bucket index is computed by a remainder unit: by a mask when BUCKETS is
// a power of two, otherwise in registered steps (reciprocal multiply,
// correction, sign fix). The slots of the bucket are then read one per cycle
// from the key and value RAMs and compared by a single comparator, followed
// by an update state. Clear skips the hash and the scan. No new request is
// taken while one is in progress (busy high). The result appears in the
// cycle in which busy drops.
// Reset empties the table at once through per-slot valid bits; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module hashed_key_value_store #(
    parameter int BUCKETS          = hkvs_pkg::DEF_BUCKETS,
    parameter int SLOTS_PER_BUCKET = hkvs_pkg::DEF_SLOTS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  hkvs_pkg::t_req i_req,
    output logic           o_valid,
    output hkvs_pkg::t_rsp o_rsp
);

    import hkvs_pkg::*;

    localparam int TOTAL = BUCKETS * SLOTS_PER_BUCKET;
    localparam int SW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int BKW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CW    = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int CNTW  = $clog2(TOTAL + 1);
    localparam logic [CW-1:0] LAST_SLOT = CW'(SLOTS_PER_BUCKET - 1);
    localparam logic [CW-1:0] SLOT_END  = CW'(SLOTS_PER_BUCKET);

    t_state           r_state,   n_state;
    t_op              r_op,      n_op;
    logic [KEY_W-1:0] r_key,     n_key;
    logic [KEY_W-1:0] r_value,   n_value;
    logic [BKW-1:0]   r_bucket,  n_bucket;
    logic [CW-1:0]    r_iss,     n_iss;
    logic             r_cmp_vld, n_cmp_vld;
    logic [CW-1:0]    r_cmp_idx, n_cmp_idx;
    logic             r_hit,     n_hit;
    logic [SW-1:0]    r_hit_idx, n_hit_idx;
    logic             r_free,    n_free;
    logic [SW-1:0]    r_free_idx, n_free_idx;
    logic [KEY_W-1:0] r_found,   n_found;
    logic [TOTAL-1:0] r_valid,   n_valid;
    logic [CNTW-1:0]  r_count,   n_count;
    t_rsp             r_rsp,     n_rsp;
    logic             r_strobe,  n_strobe;

    logic                  hash_start;
    logic                  hash_done;
    logic [BKW-1:0]        hash_bucket;
    logic [SW-1:0]         base;
    logic [SW-1:0]         rd_addr;
    logic [SW-1:0]         cmp_addr;
    logic                  rd_en;
    logic                  key_we;
    logic                  val_we;
    logic [SW-1:0]         val_waddr;
    logic [KEY_W-1:0]      key_rd;
    logic [KEY_W-1:0]      val_rd;
    logic [CNTW+COUNT_W-1:0] count_ext;

    hkvs_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hash_start),
        .i_key    (i_req.key),
        .o_done   (hash_done),
        .o_bucket (hash_bucket)
    );

    hkvs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TOTAL)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_free_idx),
        .i_wdata (r_key),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (key_rd)
    );

    hkvs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TOTAL)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (r_value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (val_rd)
    );

    assign base      = SW'(32'(r_bucket) * SLOTS_PER_BUCKET);
    assign rd_addr   = base + SW'(r_iss);
    assign cmp_addr  = base + SW'(r_cmp_idx);
    assign val_waddr = r_hit ? r_hit_idx : r_free_idx;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_value    = r_value;
        n_bucket   = r_bucket;
        n_iss      = r_iss;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_idx  = r_cmp_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_found    = r_found;
        n_valid    = r_valid;
        n_count    = r_count;
        n_rsp      = r_rsp;
        n_strobe   = 1'b0;
        hash_start = 1'b0;
        rd_en      = 1'b0;
        key_we     = 1'b0;
        val_we     = 1'b0;
        count_ext  = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_req.operation;
                    n_key   = i_req.key;
                    n_value = i_req.value;
                    if (i_req.operation == OP_CLEAR) begin
                        n_state = S_UPDATE;
                    end else begin
                        hash_start = 1'b1;
                        n_state    = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_bucket  = hash_bucket;
                    n_iss     = '0;
                    n_cmp_vld = 1'b0;
                    n_hit     = 1'b0;
                    n_free    = 1'b0;
                    n_found   = '0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                // read one slot per cycle, compare the one read the cycle before
                if (r_iss != SLOT_END) begin
                    rd_en     = 1'b1;
                    n_iss     = r_iss + CW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_iss;
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if (r_cmp_vld) begin
                    if (r_valid[cmp_addr]) begin
                        if (!r_hit && (key_rd == r_key)) begin
                            n_hit     = 1'b1;
                            n_hit_idx = cmp_addr;
                            n_found   = val_rd;
                        end
                    end else if (!r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = cmp_addr;
                    end
                    if (r_cmp_idx == LAST_SLOT) begin
                        n_state = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                n_rsp.status          = STAT_DONE;
                n_rsp.key_was_present = r_hit;
                n_rsp.found_value     = '0;
                case (r_op)
                    OP_INSERT: begin
                        if (r_hit) begin
                            val_we = 1'b1;
                        end else if (r_free) begin
                            key_we              = 1'b1;
                            val_we              = 1'b1;
                            n_valid[r_free_idx] = 1'b1;
                            n_count             = r_count + CNTW'(1);
                        end else begin
                            n_rsp.status = STAT_FULL;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_hit) begin
                            n_valid[r_hit_idx] = 1'b0;
                            n_count            = r_count - CNTW'(1);
                        end else begin
                            n_rsp.status = STAT_MISSING;
                        end
                    end
                    OP_FIND: begin
                        if (r_hit) begin
                            n_rsp.found_value = r_found;
                        end else begin
                            n_rsp.status = STAT_MISSING;
                        end
                    end
                    OP_CLEAR: begin
                        n_valid               = '0;
                        n_count               = '0;
                        n_rsp.key_was_present = 1'b0;
                    end
                    default: begin
                        n_rsp.status = STAT_DONE;
                    end
                endcase
                count_ext         = {{COUNT_W{1'b0}}, n_count};
                n_rsp.entry_count = count_ext[COUNT_W-1:0];
                n_strobe          = 1'b1;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_value    <= n_value;
        r_bucket   <= n_bucket;
        r_iss      <= n_iss;
        r_cmp_vld  <= n_cmp_vld;
        r_cmp_idx  <= n_cmp_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_found    <= n_found;
        r_rsp      <= n_rsp;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_strobe;
    assign o_rsp   = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(TOTAL))
        else $error("entry count above slot total");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("entry count differs from valid slots");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_UPDATE))
        else $error("result strobe without update cycle");

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

endmodule

### test/tb_hashed_key_value_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_key_value_store
// self-checking bench for the bucketed key-value store
// ----------------------------------------------------------------------------
// A short directed sequence covers the key extremes, every operation, updates
// in place, missing keys, full buckets and clear. Random traffic then works on
// a small pool of keys packed into a few buckets so that hits, removes and
// refusals happen often. A sweep fills every slot of the table. Each accepted
// request updates a local copy of the table, and each response is compared
// field by field with the oldest awaited one. Request gaps vary at random.
// ----------------------------------------------------------------------------
module tb_hashed_key_value_store;
    import hkvs_pkg::*;

    localparam int BUCKETS     = DEF_BUCKETS;
    localparam int SLOTS       = DEF_SLOTS;
    localparam int TABLE_SLOTS = BUCKETS * SLOTS;
    localparam int POOL_SIZE   = 24;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    t_req  req = '0;
    logic  rsp_valid;
    t_rsp  rsp;

    t_req  request_queue[$];
    t_rsp  awaited_rsp[$];
    t_rsp  got_rsp;

    logic [KEY_W-1:0] table_key[TABLE_SLOTS];
    logic [KEY_W-1:0] table_value[TABLE_SLOTS];
    bit               table_valid[TABLE_SLOTS];
    int               stored_total = 0;

    int errors = 0;
    int gap_left = 0;
    bit burst_mode = 1'b0;

    hashed_key_value_store DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (req),
        .o_valid (rsp_valid),
        .o_rsp   (rsp)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // table update for one accepted transaction
    function automatic t_rsp table_apply(t_req r);
        t_rsp res;
        int   rem;
        int   base;
        int   hit;
        int   free_slot;
        res = '0;
        res.status = STAT_DONE;
        if (r.operation == OP_CLEAR) begin
            for (int s = 0; s < TABLE_SLOTS; s++) table_valid[s] = 1'b0;
            stored_total = 0;
        end else begin
            rem = int'(r.key) % BUCKETS;
            if (rem < 0) rem += BUCKETS;
            base = rem * SLOTS;
            hit = -1;
            free_slot = -1;
            for (int s = base; s < base + SLOTS; s++) begin
                if (table_valid[s]) begin
                    if (hit < 0 && table_key[s] == r.key) hit = s;
                end else if (free_slot < 0) begin
                    free_slot = s;
                end
            end
            res.key_was_present = (hit >= 0);
            case (r.operation)
                OP_INSERT: begin
                    if (hit >= 0) begin
                        table_value[hit] = r.value;
                    end else if (free_slot >= 0) begin
                        table_key[free_slot] = r.key;
                        table_value[free_slot] = r.value;
                        table_valid[free_slot] = 1'b1;
                        stored_total++;
                    end else begin
                        res.status = STAT_FULL;
                    end
                end
                OP_REMOVE: begin
                    if (hit >= 0) begin
                        table_valid[hit] = 1'b0;
                        stored_total--;
                    end else begin
                        res.status = STAT_MISSING;
                    end
                end
                default: begin
                    if (hit >= 0) res.found_value = table_value[hit];
                    else res.status = STAT_MISSING;
                end
            endcase
        end
        res.entry_count = stored_total[COUNT_W-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (burst_mode || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 4);
        if (r < 95) return $urandom_range(5, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_req(t_op op, logic [KEY_W-1:0] k, logic [KEY_W-1:0] v);
        t_req r;
        r.operation = op;
        r.key = k;
        r.value = v;
        request_queue.push_back(r);
    endtask

    task automatic check_field(string name, logic [KEY_W-1:0] exp_v, logic [KEY_W-1:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else begin
            if (start && !busy) begin
                awaited_rsp.push_back(table_apply(req));
                if ($urandom_range(39) == 0) burst_mode = !burst_mode;
                gap_left = pick_gap();
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    start <= 1'b1;
                    req <= request_queue.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && rsp_valid) begin
            got_rsp = rsp;
            if (awaited_rsp.size() == 0) begin
                $display("%0t: response with none awaited, expected none actual %0h",
                         $time, got_rsp);
                errors++;
            end else begin
                t_rsp exp_rsp;
                exp_rsp = awaited_rsp.pop_front();
                check_field("status", KEY_W'(exp_rsp.status), KEY_W'(got_rsp.status));
                check_field("key_was_present", KEY_W'(exp_rsp.key_was_present),
                            KEY_W'(got_rsp.key_was_present));
                check_field("found_value", exp_rsp.found_value, got_rsp.found_value);
                check_field("entry_count", KEY_W'(exp_rsp.entry_count),
                            KEY_W'(got_rsp.entry_count));
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] pool[POOL_SIZE];
        logic [KEY_W-1:0] filled[$];
        logic [5:0]       hot[4];
        logic [KEY_W-1:0] k;
        int               r;

        // directed
        add_req(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        add_req(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
        add_req(OP_INSERT, 32'hFFFF_FFFF, 32'h1234_5678);
        add_req(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
        add_req(OP_INSERT, 32'h0000_0000, 32'h7FFF_FFFF);
        add_req(OP_FIND,   32'h0000_0000, $urandom);
        add_req(OP_FIND,   32'h8000_0000, $urandom);
        add_req(OP_FIND,   32'h0000_0040, $urandom);
        add_req(OP_REMOVE, 32'h0000_0040, $urandom);
        add_req(OP_INSERT, 32'h0000_0040, 32'h0000_0001);
        add_req(OP_INSERT, 32'hFFFF_FFC0, 32'h0000_0002);
        add_req(OP_INSERT, 32'h0000_0080, 32'h0000_0003);
        add_req(OP_INSERT, 32'h0000_0040, 32'hA5A5_5A5A);
        add_req(OP_FIND,   32'h0000_0080, $urandom);
        add_req(OP_REMOVE, 32'h8000_0000, $urandom);
        add_req(OP_INSERT, 32'h0000_0080, 32'h0000_0004);
        add_req(OP_FIND,   32'h0000_0080, $urandom);
        add_req(OP_REMOVE, 32'hFFFF_FFFF, $urandom);
        add_req(OP_FIND,   32'hFFFF_FFFF, $urandom);
        add_req(OP_FIND,   32'h7FFF_FFFF, $urandom);
        add_req(OP_CLEAR,  32'h0000_0000, $urandom);
        add_req(OP_FIND,   32'h0000_0000, $urandom);
        add_req(OP_CLEAR,  $urandom, $urandom);
        add_req(OP_REMOVE, 32'h0000_0000, $urandom);

        // keys crowded into a few buckets so chains overflow
        for (int h = 0; h < 4; h++) hot[h] = 6'($urandom);
        for (int p = 0; p < POOL_SIZE; p++) begin
            k = $urandom;
            k[5:0] = hot[p % 4];
            pool[p] = k;
        end
        for (int n = 0; n < 220; n++) begin
            r = $urandom_range(99);
            k = ($urandom_range(9) == 0) ? $urandom : pool[$urandom_range(POOL_SIZE - 1)];
            if (r < 2) add_req(OP_CLEAR, $urandom, $urandom);
            else if (r < 48) add_req(OP_INSERT, k, $urandom);
            else if (r < 70) add_req(OP_REMOVE, k, $urandom);
            else add_req(OP_FIND, k, $urandom);
        end

        // fill every slot of the table, then push a few refused inserts
        add_req(OP_CLEAR, $urandom, $urandom);
        for (int b = 0; b < BUCKETS; b++) begin
            for (int j = 0; j < SLOTS; j++) begin
                k = $urandom;
                k[5:0] = 6'(b);
                filled.push_back(k);
                add_req(OP_INSERT, k, $urandom);
            end
        end
        for (int n = 0; n < 8; n++) add_req(OP_INSERT, $urandom, $urandom);
        for (int n = 0; n < 30; n++) begin
            r = $urandom_range(2);
            k = filled[$urandom_range(filled.size() - 1)];
            if (r == 0) add_req(OP_INSERT, k, $urandom);
            else if (r == 1) add_req(OP_REMOVE, k, $urandom);
            else add_req(OP_FIND, k, $urandom);
        end
        add_req(OP_CLEAR, $urandom, $urandom);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() > 0 || start) @(posedge clk);
        while (awaited_rsp.size() > 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
